// ===== sv/qjht_pkg.sv =====
// Shared types, codes and defaults for the quintic joint homing trajectory block.
package qjht_pkg;

  // Default number of joints served per control period.
  localparam int NUM_JOINTS_DEF = 16;
  // Depth of the queue between the front sequencer and the evaluation back end.
  localparam int QDEPTH = 4;

  localparam logic [23:0] TICK_MAX = 24'hFFFFFF;
  localparam logic [30:0] ONE_Q30  = 31'h40000000;

  // Configuration register indexes.
  localparam logic [1:0] REG_INIT_WAIT = 2'd0;
  localparam logic [1:0] REG_TRANS     = 2'd1;
  localparam logic [1:0] REG_RECIP     = 2'd2;
  localparam logic [1:0] REG_VSCALE    = 2'd3;

  // Configuration reset values.
  localparam logic [23:0] INIT_WAIT_RST = 24'd1000;
  localparam logic [23:0] TRANS_RST     = 24'd2000;
  localparam logic [31:0] RECIP_RST     = 32'd2147484;
  localparam logic [31:0] VSCALE_RST    = 32'd32768;

  // Reported status codes.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_STOP = 2'd2;

  typedef enum logic [1:0] {PH_WAIT, PH_CAPT, PH_TRAJ, PH_STOP} phase_t;

  // What the back end does with one queued item.
  typedef enum logic [1:0] {OP_PASS, OP_CAPT, OP_EVAL, OP_HOLD} op_t;

  typedef enum logic [3:0] {
    B_IDLE, B_RD, B_HOLD, B_S, B_P2, B_P3, B_P4, B_P5, B_POLY,
    B_DPL, B_DPH, B_DVL, B_DVH, B_ML, B_MH, B_EMIT
  } bstate_t;

  typedef struct packed {
    logic [23:0] init_wait;
    logic [23:0] trans;
    logic [31:0] recip;
    logic [31:0] vscale;
  } cfg_t;

  typedef struct packed {
    op_t                op;
    logic [3:0]         joint;
    logic signed [31:0] cur;
    logic signed [31:0] tgt;
    logic [23:0]        elapsed;
    logic [1:0]         status;
  } item_t;

endpackage

// ===== sv/quintic_joint_homing_trajectory.sv =====
// Top level of the joint homing block with a minimum-jerk quintic trajectory.
// Each control period brings one item per joint (tlast on the final one), and each
// item yields exactly one command in the same order. The front sequencer takes an
// item per cycle while its four-entry queue has room; the back end works on one
// item at a time: a trajectory item steps a single shared multiplier through
// normalized time, four powers, two split products for position and velocity and
// a two-part velocity scaling, a held position reads the last-position store and a
// pass-through item goes straight out; output waits stall it. Both position stores
// are small RAMs indexed by joint; the last-position store reads zero until written.
module quintic_joint_homing_trajectory #(
  parameter int NUM_JOINTS = qjht_pkg::NUM_JOINTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // joint_index[3:0], current_pos[35:4], target_pos[67:36], zero fill
  input  logic [71:0] s_tdata,
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_joint[3:0], cmd_pos[35:4], cmd_vel[67:36], zero fill
  output logic [71:0] m_tdata,
  // cmd_write[0], status[2:1]
  output logic [2:0]  m_tuser
);

  qjht_pkg::cfg_t     cfg;
  qjht_pkg::item_t    push_item;
  qjht_pkg::item_t    pop_item;
  logic               push, pop, full, empty;
  logic [3:0]         out_joint;
  logic signed [31:0] out_pos, out_vel;
  logic               out_write;
  logic [1:0]         out_status;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.init_wait <= qjht_pkg::INIT_WAIT_RST;
      cfg.trans     <= qjht_pkg::TRANS_RST;
      cfg.recip     <= qjht_pkg::RECIP_RST;
      cfg.vscale    <= qjht_pkg::VSCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        qjht_pkg::REG_INIT_WAIT: cfg.init_wait <= cfg_wdata[23:0];
        qjht_pkg::REG_TRANS:     cfg.trans     <= cfg_wdata[23:0];
        qjht_pkg::REG_RECIP:     cfg.recip     <= cfg_wdata;
        qjht_pkg::REG_VSCALE:    cfg.vscale    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  qjht_front #(.NUM_JOINTS(NUM_JOINTS)) u_front (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .joint(s_tdata[3:0]), .cur($signed(s_tdata[35:4])), .tgt($signed(s_tdata[67:36])),
    .last(s_tlast), .push(push), .item(push_item), .full(full)
  );

  qjht_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_item(push_item), .full(full),
    .pop(pop), .pop_item(pop_item), .empty(empty)
  );

  qjht_back #(.NUM_JOINTS(NUM_JOINTS)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .empty(empty), .pop_item(pop_item), .pop(pop),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_joint(out_joint),
    .out_pos(out_pos), .out_vel(out_vel), .out_write(out_write), .out_status(out_status)
  );

  assign m_tdata = {4'd0, out_vel, out_pos, out_joint};
  assign m_tuser = {out_status, out_write};

endmodule

// ===== sv/qjht_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module qjht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/qjht_queue.sv =====
// Short in-order queue of classified items between front and back end.
module qjht_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  qjht_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output qjht_pkg::item_t pop_item,
  output logic            empty
);

  localparam int PW = (qjht_pkg::QDEPTH > 1) ? $clog2(qjht_pkg::QDEPTH) : 1;

  qjht_pkg::item_t slots [qjht_pkg::QDEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     count;

  assign full     = (count == (PW + 1)'(qjht_pkg::QDEPTH));
  assign empty    = (count == '0);
  assign pop_item = slots[rd_ptr];

  // Pointer and occupancy bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PW'(qjht_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PW'(qjht_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PW + 1)'(push && !full) - (PW + 1)'(pop && !empty);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== sv/qjht_front.sv =====
// Front end: accepts joint items, runs the phase sequencer and classifies each item.
module qjht_front #(
  parameter int NUM_JOINTS = qjht_pkg::NUM_JOINTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  qjht_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         joint,
  input  logic signed [31:0] cur,
  input  logic signed [31:0] tgt,
  input  logic               last,
  output logic               push,
  output qjht_pkg::item_t    item,
  input  logic               full
);

  qjht_pkg::phase_t phase;
  qjht_pkg::phase_t phase_next;
  logic [23:0]      elapsed;
  logic [23:0]      elapsed_next;
  logic             accept;
  logic             jvalid;

  assign in_ready = !full;
  assign accept   = in_valid && !full;
  assign push     = accept;
  assign jvalid   = (int'(joint) < NUM_JOINTS);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= qjht_pkg::PH_WAIT;
      elapsed <= '0;
    end else begin
      phase   <= phase_next;
      elapsed <= elapsed_next;
    end
  end

  // The item that closes a control period advances the sequencer.
  always_comb begin
    phase_next   = phase;
    elapsed_next = elapsed;
    if (accept && last) begin
      unique case (phase)
        qjht_pkg::PH_WAIT: begin
          if (elapsed >= cfg.init_wait) begin
            phase_next   = qjht_pkg::PH_CAPT;
            elapsed_next = '0;
          end else if (elapsed != qjht_pkg::TICK_MAX) begin
            elapsed_next = elapsed + 24'd1;
          end
        end
        qjht_pkg::PH_CAPT: begin
          phase_next   = qjht_pkg::PH_TRAJ;
          elapsed_next = '0;
        end
        qjht_pkg::PH_TRAJ: begin
          if (elapsed > cfg.trans || elapsed == qjht_pkg::TICK_MAX) begin
            phase_next = qjht_pkg::PH_STOP;
          end else begin
            elapsed_next = elapsed + 24'd1;
          end
        end
        qjht_pkg::PH_STOP: begin
          phase_next = qjht_pkg::PH_STOP;
        end
        default: phase_next = qjht_pkg::PH_WAIT;
      endcase
    end
  end

  // Classify the item by phase and joint range.
  always_comb begin
    item.joint   = joint;
    item.cur     = cur;
    item.tgt     = tgt;
    item.elapsed = elapsed;
    item.op      = qjht_pkg::OP_PASS;
    item.status  = qjht_pkg::ST_IDLE;
    unique case (phase)
      qjht_pkg::PH_WAIT: begin
        item.status = qjht_pkg::ST_IDLE;
      end
      qjht_pkg::PH_CAPT: begin
        item.status = qjht_pkg::ST_RUN;
        if (jvalid) item.op = qjht_pkg::OP_CAPT;
      end
      qjht_pkg::PH_TRAJ: begin
        item.status = qjht_pkg::ST_RUN;
        if (jvalid) begin
          item.op = (elapsed <= cfg.trans) ? qjht_pkg::OP_EVAL : qjht_pkg::OP_HOLD;
        end
      end
      qjht_pkg::PH_STOP: begin
        item.status = qjht_pkg::ST_STOP;
        if (jvalid) item.op = qjht_pkg::OP_HOLD;
      end
      default: item.status = qjht_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== sv/qjht_back.sv =====
// Back end: evaluates the quintic with one shared multiplier and drives the result register.
module qjht_back #(
  parameter int NUM_JOINTS = qjht_pkg::NUM_JOINTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  qjht_pkg::cfg_t     cfg,
  input  logic               empty,
  input  qjht_pkg::item_t    pop_item,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_joint,
  output logic signed [31:0] out_pos,
  output logic signed [31:0] out_vel,
  output logic               out_write,
  output logic [1:0]         out_status
);

  localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

  qjht_pkg::bstate_t  state;
  qjht_pkg::bstate_t  state_next;
  qjht_pkg::item_t    it;
  logic [JW-1:0]      idx;
  logic               out_free;

  // Start and last position stores.
  logic               start_we;
  logic               last_we;
  logic [31:0]        start_rd;
  logic [31:0]        last_rd;
  logic               lp_valid [NUM_JOINTS];
  logic               lpv_q;

  // Shared multiplier.
  logic signed [40:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [73:0] mul_y;

  // Working registers.
  logic [30:0]        s_q, s2_q, s3_q, s4_q, s5_q;
  logic signed [35:0] p_q, v_q;
  logic signed [32:0] delta_q;
  logic signed [31:0] start_q;
  logic signed [69:0] acc_q;
  logic [39:0]        mag_q;
  logic               neg_q;
  logic [39:0]        rlo_q;
  logic signed [31:0] pos_q, vel_q;

  // Combinational step results.
  logic [55:0]        sraw;
  logic signed [39:0] p_full, v_full;
  logic signed [69:0] tsum;
  logic signed [40:0] psum;
  logic signed [39:0] dv;
  logic [56:0]        rsum;
  logic [31:0]        rc;

  assign idx      = JW'(it.joint);
  assign out_free = !out_valid || out_ready;
  assign mul_y    = mul_a * mul_b;

  qjht_ram #(.WIDTH(32), .DEPTH(NUM_JOINTS)) u_start (
    .clk(clk), .we(start_we), .waddr(idx), .wdata(it.cur),
    .raddr(idx), .rdata(start_rd)
  );

  qjht_ram #(.WIDTH(32), .DEPTH(NUM_JOINTS)) u_last (
    .clk(clk), .we(last_we), .waddr(idx), .wdata(pos_q),
    .raddr(idx), .rdata(last_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qjht_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Step sequence per item kind.
  always_comb begin
    state_next = state;
    unique case (state)
      qjht_pkg::B_IDLE: if (!empty) state_next = qjht_pkg::B_RD;
      qjht_pkg::B_RD: begin
        if (it.op == qjht_pkg::OP_EVAL)      state_next = qjht_pkg::B_S;
        else if (it.op == qjht_pkg::OP_HOLD) state_next = qjht_pkg::B_HOLD;
        else                                 state_next = qjht_pkg::B_EMIT;
      end
      qjht_pkg::B_HOLD: state_next = qjht_pkg::B_EMIT;
      qjht_pkg::B_S:    state_next = qjht_pkg::B_P2;
      qjht_pkg::B_P2:   state_next = qjht_pkg::B_P3;
      qjht_pkg::B_P3:   state_next = qjht_pkg::B_P4;
      qjht_pkg::B_P4:   state_next = qjht_pkg::B_P5;
      qjht_pkg::B_P5:   state_next = qjht_pkg::B_POLY;
      qjht_pkg::B_POLY: state_next = qjht_pkg::B_DPL;
      qjht_pkg::B_DPL:  state_next = qjht_pkg::B_DPH;
      qjht_pkg::B_DPH:  state_next = qjht_pkg::B_DVL;
      qjht_pkg::B_DVL:  state_next = qjht_pkg::B_DVH;
      qjht_pkg::B_DVH:  state_next = qjht_pkg::B_ML;
      qjht_pkg::B_ML:   state_next = qjht_pkg::B_MH;
      qjht_pkg::B_MH:   state_next = qjht_pkg::B_EMIT;
      qjht_pkg::B_EMIT: if (out_free) state_next = qjht_pkg::B_IDLE;
      default:          state_next = qjht_pkg::B_IDLE;
    endcase
  end

  // Control outputs and multiplier operand selection.
  always_comb begin
    pop      = (state == qjht_pkg::B_IDLE) && !empty;
    start_we = (state == qjht_pkg::B_RD) && (it.op == qjht_pkg::OP_CAPT);
    last_we  = (state == qjht_pkg::B_EMIT) && out_free && (it.op == qjht_pkg::OP_EVAL);
    mul_a    = '0;
    mul_b    = '0;
    unique case (state)
      qjht_pkg::B_S: begin
        mul_a = $signed({17'd0, it.elapsed});
        mul_b = $signed({1'b0, cfg.recip});
      end
      qjht_pkg::B_P2: begin
        mul_a = $signed({10'd0, s_q});
        mul_b = $signed({2'd0, s_q});
      end
      qjht_pkg::B_P3: begin
        mul_a = $signed({10'd0, s2_q});
        mul_b = $signed({2'd0, s_q});
      end
      qjht_pkg::B_P4: begin
        mul_a = $signed({10'd0, s3_q});
        mul_b = $signed({2'd0, s_q});
      end
      qjht_pkg::B_P5: begin
        mul_a = $signed({10'd0, s4_q});
        mul_b = $signed({2'd0, s_q});
      end
      qjht_pkg::B_DPL: begin
        mul_a = $signed({{8{delta_q[32]}}, delta_q});
        mul_b = $signed({15'd0, p_q[17:0]});
      end
      qjht_pkg::B_DPH: begin
        mul_a = $signed({{8{delta_q[32]}}, delta_q});
        mul_b = $signed({{15{p_q[35]}}, p_q[35:18]});
      end
      qjht_pkg::B_DVL: begin
        mul_a = $signed({{8{delta_q[32]}}, delta_q});
        mul_b = $signed({15'd0, v_q[17:0]});
      end
      qjht_pkg::B_DVH: begin
        mul_a = $signed({{8{delta_q[32]}}, delta_q});
        mul_b = $signed({{15{v_q[35]}}, v_q[35:18]});
      end
      qjht_pkg::B_ML: begin
        mul_a = $signed({1'b0, mag_q});
        mul_b = $signed({17'd0, cfg.vscale[15:0]});
      end
      qjht_pkg::B_MH: begin
        mul_a = $signed({1'b0, mag_q});
        mul_b = $signed({17'd0, cfg.vscale[31:16]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Arithmetic that follows each multiply.
  always_comb begin
    sraw   = mul_y[57:2];
    p_full = 40'sd10 * $signed({9'd0, s3_q}) - 40'sd15 * $signed({9'd0, s4_q})
           + 40'sd6 * $signed({9'd0, s5_q});
    v_full = 40'sd30 * $signed({9'd0, s2_q}) - 40'sd60 * $signed({9'd0, s3_q})
           + 40'sd30 * $signed({9'd0, s4_q});
    tsum   = acc_q + $signed({mul_y[51:0], 18'd0});
    psum   = $signed({{9{start_q[31]}}, start_q}) + $signed({tsum[69], tsum[69:30]});
    dv     = tsum[69:30];
    rsum   = {1'b0, mul_y[55:0]} + {17'd0, rlo_q};
    rc     = (rsum > 57'h80000000) ? 32'h80000000 : rsum[31:0];
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      qjht_pkg::B_IDLE: begin
        it <= pop_item;
      end
      qjht_pkg::B_RD: begin
        pos_q <= it.cur;
        vel_q <= '0;
        lpv_q <= lp_valid[idx];
      end
      qjht_pkg::B_HOLD: begin
        pos_q <= lpv_q ? $signed(last_rd) : 32'sd0;
      end
      qjht_pkg::B_S: begin
        s_q     <= (sraw >= 56'(qjht_pkg::ONE_Q30)) ? qjht_pkg::ONE_Q30 : sraw[30:0];
        start_q <= $signed(start_rd);
        delta_q <= $signed({it.tgt[31], it.tgt}) - $signed({start_rd[31], start_rd});
      end
      qjht_pkg::B_P2:   s2_q <= mul_y[60:30];
      qjht_pkg::B_P3:   s3_q <= mul_y[60:30];
      qjht_pkg::B_P4:   s4_q <= mul_y[60:30];
      qjht_pkg::B_P5:   s5_q <= mul_y[60:30];
      qjht_pkg::B_POLY: begin
        p_q <= p_full[35:0];
        v_q <= v_full[35:0];
      end
      qjht_pkg::B_DPL, qjht_pkg::B_DVL: begin
        acc_q <= mul_y[69:0];
      end
      qjht_pkg::B_DPH: begin
        if (psum > 41'sd2147483647)       pos_q <= 32'sh7FFFFFFF;
        else if (psum < -41'sd2147483648) pos_q <= 32'sh80000000;
        else                              pos_q <= psum[31:0];
      end
      qjht_pkg::B_DVH: begin
        neg_q <= dv[39];
        mag_q <= dv[39] ? 40'(-dv) : 40'(dv);
      end
      qjht_pkg::B_ML: begin
        rlo_q <= mul_y[55:16];
      end
      qjht_pkg::B_MH: begin
        if (neg_q)       vel_q <= $signed(~rc + 32'd1);
        else if (rc[31]) vel_q <= 32'sh7FFFFFFF;
        else             vel_q <= $signed(rc);
      end
      default: begin
      end
    endcase
  end

  // Positions that were never written read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_JOINTS; i++) lp_valid[i] <= 1'b0;
    end else if (last_we) begin
      lp_valid[idx] <= 1'b1;
    end
  end

  // Result register toward the output channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == qjht_pkg::B_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == qjht_pkg::B_EMIT && out_free) begin
      out_joint  <= it.joint;
      out_pos    <= pos_q;
      out_vel    <= vel_q;
      out_write  <= (it.op == qjht_pkg::OP_EVAL);
      out_status <= it.status;
    end
  end

  a_write_running: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_write |-> out_status == qjht_pkg::ST_RUN)
    else $error("position write reported outside the running status");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    state == qjht_pkg::B_EMIT && out_free |=> out_valid)
    else $error("finished item did not reach the result register");

  a_s_saturated: assert property (@(posedge clk) disable iff (rst)
    state == qjht_pkg::B_P2 |-> s_q <= qjht_pkg::ONE_Q30)
    else $error("normalized time above one");

endmodule
